// ----- sv/thc_pkg.sv -----
package thc_pkg;

   localparam int BIN_COUNT_DEF = 8;
   localparam int BIN_W         = 3;
   localparam int SAMPLE_W      = 32;
   localparam int COUNT_W       = 32;
   localparam int TOTAL_W       = 64;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [1:0]                 kind;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [BIN_W-1:0]          bin_index;
      logic [COUNT_W-1:0]        bin_count;
      logic signed [TOTAL_W-1:0] running_total;
      logic                      underflow;
   } rsp_type;

   typedef struct packed {
      logic                    write;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   wdata;
   } csr_type;

   typedef struct packed {
      logic                       valid;
      logic [1:0]                 kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       found;
      logic [BIN_W-1:0]           bin;
      logic [COUNT_W-1:0]         count;
      logic                       underflow;
   } token_type;

endpackage

// ----- sv/thc_cell.sv -----
module thc_cell #(
   parameter int BIN_COUNT  = thc_pkg::BIN_COUNT_DEF,
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  thc_pkg::csr_type    csr,
   input  thc_pkg::token_type  tok_i,
   output thc_pkg::token_type  tok_o
);

   logic                          hit;
   logic [thc_pkg::COUNT_W-1:0]   count_ff;
   logic [thc_pkg::COUNT_W-1:0]   count_in;
   thc_pkg::token_type            tok_ff;
   thc_pkg::token_type            tok_in;

   generate
      if (CELL_INDEX == BIN_COUNT - 1) begin : g_last
         assign hit = 1'b1;
      end else begin : g_limit
         logic signed [thc_pkg::SAMPLE_W-1:0] limit_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               limit_ff <= '0;
            end else if (csr.write && csr.index == thc_pkg::CSR_INDEX_W'(CELL_INDEX)) begin
               limit_ff <= csr.wdata[thc_pkg::SAMPLE_W-1:0];
            end
         end

         assign hit = tok_i.sample < limit_ff;
      end
   endgenerate

   always_comb begin
      tok_in   = tok_i;
      count_in = count_ff;
      if (tok_i.valid) begin
         if (tok_i.kind == thc_pkg::KIND_CLEAR) begin
            count_in = '0;
            if (!tok_i.found) begin
               tok_in.found     = 1'b1;
               tok_in.bin       = '0;
               tok_in.count     = '0;
               tok_in.underflow = 1'b0;
            end
         end else if (!tok_i.found && hit) begin
            tok_in.found     = 1'b1;
            tok_in.bin       = thc_pkg::BIN_W'(CELL_INDEX);
            tok_in.underflow = 1'b0;
            if (tok_i.kind == thc_pkg::KIND_ADD) begin
               if (count_ff != thc_pkg::COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
            end else if (count_ff == '0) begin
               tok_in.underflow = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
            end
            tok_in.count = count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         count_ff     <= '0;
      end else if (advance) begin
         tok_ff   <= tok_in;
         count_ff <= count_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

// ----- sv/threshold_histogram_counter_unit.sv -----
// Channel   Direction  Payload             Handshake
// req_      in         thc_pkg::req_type   req_valid / req_stall
// rsp_      out        thc_pkg::rsp_type   rsp_valid / rsp_stall
// csr_      in         32-bit limit write  csr_write, csr_index, csr_wdata
//
// A beat passes the BIN_COUNT registered bin cells, then the rsp_ register; the chain
// shifts unless rsp_stall holds a waiting result, and otherwise sustains one beat per cycle.
// A beat that names the unused kind is accepted and gives no result.
// Reset is synchronous and clears every bin count, the total and all limits.
// When rsp_stall holds a waiting result, the whole chain freezes and req_stall rises.
module threshold_histogram_counter_unit #(
   parameter int BIN_COUNT = thc_pkg::BIN_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  thc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output thc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write,
   input  logic [thc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [thc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                                  advance;
   thc_pkg::csr_type                      csr;
   thc_pkg::token_type                    tok [0:BIN_COUNT];
   thc_pkg::token_type                    chain_out;
   logic signed [thc_pkg::TOTAL_W-1:0]    total_ff;
   logic signed [thc_pkg::TOTAL_W-1:0]    total_in;
   logic signed [thc_pkg::TOTAL_W:0]      sum_wide;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   thc_pkg::rsp_type                      rsp_data_ff;
   thc_pkg::rsp_type                      rsp_data_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign csr.write = csr_write;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   always_comb begin
      tok[0]           = '0;
      tok[0].valid     = req_valid && req_data.kind != thc_pkg::KIND_NONE;
      tok[0].kind      = req_data.kind;
      tok[0].sample    = req_data.sample;
   end

   generate
      for (genvar i = 0; i < BIN_COUNT; i++) begin : g_cell
         thc_cell #(
            .BIN_COUNT  (BIN_COUNT),
            .CELL_INDEX (i)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .csr     (csr),
            .tok_i   (tok[i]),
            .tok_o   (tok[i+1])
         );
      end
   endgenerate

   assign chain_out = tok[BIN_COUNT];

   assign sum_wide = {total_ff[thc_pkg::TOTAL_W-1], total_ff}
                   + {{(thc_pkg::TOTAL_W - thc_pkg::SAMPLE_W + 1){chain_out.sample[thc_pkg::SAMPLE_W-1]}},
                      chain_out.sample};

   always_comb begin
      total_in = total_ff;
      if (chain_out.valid) begin
         case (chain_out.kind)
            thc_pkg::KIND_ADD: begin
               if (sum_wide[thc_pkg::TOTAL_W] != sum_wide[thc_pkg::TOTAL_W-1]) begin
                  total_in = sum_wide[thc_pkg::TOTAL_W]
                           ? {1'b1, {(thc_pkg::TOTAL_W-1){1'b0}}}
                           : {1'b0, {(thc_pkg::TOTAL_W-1){1'b1}}};
               end else begin
                  total_in = sum_wide[thc_pkg::TOTAL_W-1:0];
               end
            end
            thc_pkg::KIND_CLEAR: total_in = '0;
            default:             total_in = total_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in              = chain_out.valid;
      rsp_data_in.bin_index     = chain_out.bin;
      rsp_data_in.bin_count     = chain_out.count;
      rsp_data_in.running_total = total_in;
      rsp_data_in.underflow     = chain_out.underflow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_token_found : assert property (@(posedge clock) disable iff (reset)
      chain_out.valid |-> chain_out.found)
      else $error("token left the chain without a bin");

   a_clear_total : assert property (@(posedge clock) disable iff (reset)
      (advance && chain_out.valid && chain_out.kind == thc_pkg::KIND_CLEAR) |=> total_ff == '0)
      else $error("total not zero after clear");

   a_underflow_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.underflow) |-> rsp_data.bin_count == '0)
      else $error("underflow with nonzero count");

   a_bin_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.bin_index < thc_pkg::BIN_W'(BIN_COUNT - 1) ||
                    rsp_data.bin_index == thc_pkg::BIN_W'(BIN_COUNT - 1))
      else $error("bin index beyond bin count");

endmodule
